// ----- rtl/core/map_frame_deaggregator_macros.svh -----
// Assertion macros for the frame deaggregator checker.
// Needs nothing else; included by the files that carry assertions.
`ifndef MAP_FRAME_DEAGGREGATOR_MACROS_SVH
`define MAP_FRAME_DEAGGREGATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MFD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/mfd_pkg.sv -----
// Shared types and constants of the frame deaggregator.
// No dependencies; imported by every module of the block.
`default_nettype none

package mfd_pkg;

    localparam int HEADER_BYTES   = 4;
    localparam int HDR_LAST       = HEADER_BYTES - 1;
    localparam int HDR_W          = HEADER_BYTES * 8;
    localparam int BEAT_W         = $clog2(HEADER_BYTES);
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] STAT_DATA      = 2'd0;
    localparam logic [1:0] STAT_MALFORMED = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        buffer_start;
        logic [15:0] buffer_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_first;
        logic       frame_final;
        logic [1:0] drop_status;
        logic       run_last;
    } out_item_t;

    // One queued job: either a whole header burst or a single result beat.
    typedef struct packed {
        logic             burst;
        logic [HDR_W-1:0] bytes;       // byte i of the header at [8*i +: 8]
        logic             final_mark;
        logic [1:0]       status;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/mfd_queue.sv -----
// Small job queue between the classifier and the beat emitter.
// Depends on mfd_pkg (entry_t, q_stat_t).
`default_nettype none

module mfd_queue #(
    parameter int DEPTH = mfd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  mfd_pkg::entry_t      push_entry,
    input  wire logic            pop,
    output mfd_pkg::entry_t      head,
    output mfd_pkg::q_stat_t     qstat
);
    import mfd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign head        = mem_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mfd_front.sv -----
// Classifier: tracks buffer and frame position per input byte and queues jobs.
// Depends on mfd_pkg.
`default_nettype none

module mfd_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_valid,
    output logic              item_ready,
    input  mfd_pkg::in_item_t item,
    output logic              push,
    output mfd_pkg::entry_t   push_entry,
    input  mfd_pkg::q_stat_t  qstat
);
    import mfd_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_DISCARD
    } phase_t;

    phase_t            phase_reg,  phase_next;
    logic [BEAT_W-1:0] hidx_reg,   hidx_next;
    logic [15:0]       frame_reg,  frame_next;
    logic [15:0]       buf_reg,    buf_next;
    logic [7:0]        hstore_reg [HDR_LAST];

    logic              fire;
    logic              store_we;
    phase_t            ph;
    logic [BEAT_W-1:0] hi;
    logic [15:0]       bl;
    logic [15:0]       bl1;
    logic [15:0]       fl;
    logic [15:0]       fl1;
    logic [15:0]       pay;

    assign item_ready = !qstat.full;
    assign fire       = item_valid && item_ready;

    always_comb
    begin
        // a buffer start resets position before the byte is counted
        bl  = item.buffer_start ? item.buffer_length : buf_reg;
        ph  = item.buffer_start ? PH_HEADER : phase_reg;
        hi  = item.buffer_start ? '0 : hidx_reg;
        fl  = item.buffer_start ? '0 : frame_reg;
        bl1 = bl - 16'd1;
        fl1 = fl - 16'd1;
        pay = {hstore_reg[HEADER_BYTES-2], item.data_byte};

        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        frame_next = frame_reg;
        buf_next   = buf_reg;
        push       = 1'b0;
        push_entry = '0;
        store_we   = 1'b0;

        if (fire)
        begin
            phase_next = ph;
            hidx_next  = hi;
            frame_next = fl;
            buf_next   = bl;
            if (bl != 16'd0)
            begin
                buf_next = bl1;
                unique case (ph)
                    PH_BODY:
                    begin
                        frame_next               = fl1;
                        push                     = 1'b1;
                        push_entry.bytes[7:0]    = item.data_byte;
                        push_entry.final_mark    = (fl1 == 16'd0);
                        push_entry.status        = STAT_DATA;
                        if (fl1 == 16'd0)
                        begin
                            phase_next = PH_HEADER;
                            hidx_next  = '0;
                        end
                    end
                    PH_HEADER:
                    begin
                        if (hi != BEAT_W'(HDR_LAST))
                        begin
                            store_we  = 1'b1;
                            hidx_next = hi + 1'b1;
                            if (bl1 == 16'd0)
                            begin
                                // buffer ran out inside a header
                                phase_next        = PH_DISCARD;
                                hidx_next         = '0;
                                push              = 1'b1;
                                push_entry.status = STAT_MALFORMED;
                            end
                        end
                        else
                        begin
                            hidx_next = '0;
                            if (pay == 16'd0)
                            begin
                                phase_next        = PH_DISCARD;
                                push              = 1'b1;
                                push_entry.status = STAT_EMPTY;
                            end
                            else if (pay > bl1)
                            begin
                                phase_next        = PH_DISCARD;
                                push              = 1'b1;
                                push_entry.status = STAT_MALFORMED;
                            end
                            else
                            begin
                                phase_next       = PH_BODY;
                                frame_next       = pay;
                                push             = 1'b1;
                                push_entry.burst = 1'b1;
                                for (int i = 0; i < HDR_LAST; i++)
                                begin
                                    push_entry.bytes[8*i +: 8] = hstore_reg[i];
                                end
                                push_entry.bytes[8*HDR_LAST +: 8] = item.data_byte;
                            end
                        end
                    end
                    default:
                    begin
                        // discard: byte only counted off the buffer
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hidx_reg  <= '0;
            frame_reg <= '0;
            buf_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            frame_reg <= frame_next;
            buf_reg   <= buf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            hstore_reg[hi] <= item.data_byte;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mfd_back.sv -----
// Beat emitter: expands queued jobs into result beats behind an output register.
// Depends on mfd_pkg.
`default_nettype none

module mfd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  mfd_pkg::entry_t    head,
    input  mfd_pkg::q_stat_t   qstat,
    output logic               pop,
    output logic               result_valid,
    input  wire logic          result_ready,
    output mfd_pkg::out_item_t result
);
    import mfd_pkg::*;

    logic [BEAT_W-1:0] beat_reg;
    logic              ov_reg;
    out_item_t         res_reg;
    out_item_t         res_next;
    logic              load;
    logic              last_beat;

    assign load      = !qstat.empty && (!ov_reg || result_ready);
    assign last_beat = !head.burst || (beat_reg == BEAT_W'(HDR_LAST));
    assign pop       = load && last_beat;

    always_comb
    begin
        if (head.burst)
        begin
            res_next.out_byte    = head.bytes[{beat_reg, 3'b000} +: 8];
            res_next.frame_first = (beat_reg == '0);
            res_next.frame_final = 1'b0;
            res_next.drop_status = STAT_DATA;
            res_next.run_last    = last_beat;
        end
        else
        begin
            res_next.out_byte    = head.bytes[7:0];
            res_next.frame_first = 1'b0;
            res_next.frame_final = head.final_mark;
            res_next.drop_status = head.status;
            res_next.run_last    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else if (load)
        begin
            ov_reg   <= 1'b1;
            beat_reg <= pop ? '0 : beat_reg + 1'b1;
        end
        else if (result_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = ov_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

// ----- rtl/core/map_frame_deaggregator.sv -----
// Frame deaggregator: splits a length-prefixed aggregated byte stream into frames.
// Input channel (item_valid/item_ready/item) takes one buffer byte per beat; the
// first byte of a buffer carries buffer_start and the buffer length.
// Output channel (result_valid/result_ready/result) gives one result per beat:
// frame bytes with first/final marks, or a single malformed/empty status.
// A body byte gives one result via the job queue and the output register. The last
// header byte gives the four header bytes as consecutive beats. Input runs at one
// byte per cycle while the queue is not full; the output register emits one beat
// per cycle while result_ready is high, so a burst of headers is paced by the
// emitter and absorbed by the job queue (QUEUE_DEPTH jobs) before item_ready drops.
// Reset clears the position state: the block waits for a buffer start, and bytes
// seen before one are ignored. When the receiver stalls, the result stays held,
// the queue fills and item_ready goes low once it is full; nothing is lost.
// Depends on mfd_pkg, mfd_front, mfd_queue, mfd_back.
`default_nettype none

module map_frame_deaggregator #(
    parameter int QUEUE_DEPTH = mfd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_ready,
    input  mfd_pkg::in_item_t  item,
    output logic               result_valid,
    input  wire logic          result_ready,
    output mfd_pkg::out_item_t result
);
    import mfd_pkg::*;

    logic    push;
    logic    pop;
    entry_t  push_entry;
    entry_t  head;
    q_stat_t qstat;

    mfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .push_entry (push_entry),
        .qstat      (qstat)
    );

    mfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    mfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- rtl/core/mfd_checker.sv -----
// Port-level checks on the frame deaggregator, bound to the top level.
// Depends on mfd_pkg and map_frame_deaggregator_macros.svh.
`default_nettype none
`include "map_frame_deaggregator_macros.svh"

module mfd_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          result_valid,
    input wire logic          result_ready,
    input mfd_pkg::out_item_t result
);
    import mfd_pkg::*;

    `MFD_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")

    `MFD_ASSERT_NOW(a_status_alone, clk, rst_n, result_valid && (result.drop_status != STAT_DATA), result.run_last && !result.frame_first && !result.frame_final && (result.out_byte == 8'd0), "status beat carries frame data")

    `MFD_ASSERT_NOW(a_first_not_final, clk, rst_n, result_valid && result.frame_first, !result.frame_final && (result.drop_status == STAT_DATA) && !result.run_last, "frame start beat malformed")

    `MFD_ASSERT_NOW(a_final_is_last, clk, rst_n, result_valid && result.frame_final, result.run_last && (result.drop_status == STAT_DATA), "frame end beat not a single result")

endmodule

bind map_frame_deaggregator mfd_checker u_mfd_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking bench for map_frame_deaggregator: buffer bytes go in, frame and drop beats
// come out and are compared against a cycle-free prediction of the splitter.
// Depends on mfd_pkg and the map_frame_deaggregator RTL.
module tb;
    import mfd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int ITEM_TARGET  = 370;

    typedef enum logic [1:0] {SPLIT_HEADER, SPLIT_BODY, SPLIT_DISCARD} split_phase_e;

    // Tracks where the splitter is in the buffer and holds the beats it must produce.
    class frame_split_sb;
        split_phase_e phase;
        logic [7:0]   hdr [HEADER_BYTES];
        int           hdr_count;
        logic [16:0]  frame_left;
        logic [15:0]  buffer_left;
        out_item_t    expected_beats [$];
        int           errors;

        function new();
            phase       = SPLIT_HEADER;
            hdr_count   = 0;
            frame_left  = '0;
            buffer_left = '0;
            errors      = 0;
        endfunction

        function void queue_beat(logic [7:0] b, logic first, logic fin, logic [1:0] st,
                                 logic last);
            out_item_t e;
            e.out_byte    = b;
            e.frame_first = first;
            e.frame_final = fin;
            e.drop_status = st;
            e.run_last    = last;
            expected_beats.push_back(e);
        endfunction

        function void take_byte(in_item_t it);
            logic [15:0] payload;
            if (it.buffer_start) begin
                buffer_left = it.buffer_length;
                phase       = SPLIT_HEADER;
                hdr_count   = 0;
                frame_left  = '0;
            end
            if (buffer_left == 0)
                return;
            buffer_left = buffer_left - 16'd1;

            if (phase == SPLIT_BODY) begin
                frame_left = frame_left - 17'd1;
                if (frame_left == 0) begin
                    phase     = SPLIT_HEADER;
                    hdr_count = 0;
                    queue_beat(it.data_byte, 1'b0, 1'b1, STAT_DATA, 1'b1);
                end else begin
                    queue_beat(it.data_byte, 1'b0, 1'b0, STAT_DATA, 1'b1);
                end
                return;
            end
            if (phase != SPLIT_HEADER)
                return;

            hdr[hdr_count] = it.data_byte;
            hdr_count++;
            if (hdr_count < HEADER_BYTES) begin
                // buffer ran out in the middle of a header
                if (buffer_left == 0) begin
                    phase     = SPLIT_DISCARD;
                    hdr_count = 0;
                    queue_beat(8'h00, 1'b0, 1'b0, STAT_MALFORMED, 1'b1);
                end
                return;
            end

            hdr_count = 0;
            payload   = {hdr[HEADER_BYTES-2], hdr[HEADER_BYTES-1]};
            if (payload == 0) begin
                phase = SPLIT_DISCARD;
                queue_beat(8'h00, 1'b0, 1'b0, STAT_EMPTY, 1'b1);
            end else if (payload > buffer_left) begin
                phase = SPLIT_DISCARD;
                queue_beat(8'h00, 1'b0, 1'b0, STAT_MALFORMED, 1'b1);
            end else begin
                frame_left = {1'b0, payload};
                phase      = SPLIT_BODY;
                for (int k = 0; k < HEADER_BYTES; k++)
                    queue_beat(hdr[k], k == 0, 1'b0, STAT_DATA, k == HEADER_BYTES - 1);
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_beat(out_item_t got);
            out_item_t want;
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat %h", got));
                return;
            end
            want = expected_beats.pop_front();
            if (got.out_byte != want.out_byte)
                report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            if (got.frame_first != want.frame_first)
                report_mismatch($sformatf("frame_first %b, want %b",
                                          got.frame_first, want.frame_first));
            if (got.frame_final != want.frame_final)
                report_mismatch($sformatf("frame_final %b, want %b",
                                          got.frame_final, want.frame_final));
            if (got.drop_status != want.drop_status)
                report_mismatch($sformatf("drop_status %0d, want %0d",
                                          got.drop_status, want.drop_status));
            if (got.run_last != want.run_last)
                report_mismatch($sformatf("run_last %b, want %b", got.run_last, want.run_last));
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_item_t  in_beat;
    logic      result_valid;
    logic      result_ready;
    out_item_t out_beat;

    frame_split_sb sb = new();

    int         send_idle_pct;
    int         recv_stall_pct;
    int         bytes_sent;
    int         cycles;
    logic [7:0] pending_bytes [$];

    map_frame_deaggregator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (in_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (out_beat)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_beat(out_beat);
    end

    // Called right after a posedge (or at time zero); returns right after the accepting edge.
    task automatic send_byte(logic [7:0] b, logic start, logic [15:0] len);
        in_item_t it;
        it.data_byte     = b;
        it.buffer_start  = start;
        it.buffer_length = len;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            item_valid <= 1'b0;
            in_beat    <= '{data_byte: 8'($urandom), buffer_start: 1'($urandom),
                            buffer_length: 16'($urandom)};
            @(negedge clk);
        end
        item_valid <= 1'b1;
        in_beat    <= it;
        do
            @(posedge clk);
        while (!item_ready);
        sb.take_byte(it);
        bytes_sent++;
    endtask

    task automatic send_pending(logic [15:0] claimed);
        for (int i = 0; i < pending_bytes.size(); i++)
            send_byte(pending_bytes[i], i == 0, (i == 0) ? claimed : 16'($urandom));
    endtask

    function automatic int rand_payload();
        return ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
    endfunction

    function automatic void add_frame(logic [15:0] pay, int body);
        pending_bytes.push_back(8'($urandom));
        pending_bytes.push_back(8'($urandom));
        pending_bytes.push_back(pay[15:8]);
        pending_bytes.push_back(pay[7:0]);
        repeat (body) pending_bytes.push_back(8'($urandom));
    endfunction

    // Mostly well-formed buffers; the rest hit the drop and abandon paths.
    function automatic int build_buffer();
        int kind;
        int p;
        int claimed;
        int cut;
        pending_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 70) begin
            repeat ($urandom_range(3, 1)) begin
                p = rand_payload();
                add_frame(16'(p), p);
            end
            return pending_bytes.size();
        end
        repeat ($urandom_range(2, 0)) begin
            p = rand_payload();
            add_frame(16'(p), p);
        end
        if (kind < 78) begin
            // frame overruns the buffer
            p   = ($urandom_range(3) == 0) ? $urandom_range(65535, 41) : $urandom_range(40, 1);
            cut = (p - 1 < 8) ? p - 1 : 8;
            add_frame(16'(p), $urandom_range(cut, 0));
            claimed = pending_bytes.size();
        end else if (kind < 84) begin
            add_frame(16'd0, $urandom_range(5, 0));
            claimed = pending_bytes.size();
        end else if (kind < 90) begin
            repeat ($urandom_range(HEADER_BYTES - 1, 1)) pending_bytes.push_back(8'($urandom));
            claimed = pending_bytes.size();
        end else if (kind < 95) begin
            // claims more than is sent; the next buffer start abandons it
            p = rand_payload();
            add_frame(16'(p), p);
            claimed = ($urandom_range(1) == 0)
                    ? pending_bytes.size() + $urandom_range(10, 1)
                    : $urandom_range(65535, pending_bytes.size() + 1);
            repeat ($urandom_range(pending_bytes.size() - 1, 0)) void'(pending_bytes.pop_back());
        end else begin
            // trailing bytes past the buffer end are ignored
            p = rand_payload();
            add_frame(16'(p), p);
            claimed = pending_bytes.size();
            repeat ($urandom_range(4, 1)) pending_bytes.push_back(8'($urandom));
        end
        return claimed;
    endfunction

    initial
    begin
        int claimed;
        int goal;
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        in_beat        = '0;
        result_ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bytes_sent     = 0;
        cycles         = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stray byte, zero-length buffer, good frame, oversize, empty, short header
        send_byte(8'hFF, 1'b0, 16'hFFFF);
        send_byte(8'h00, 1'b1, 16'h0000);
        pending_bytes = '{8'hAA, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'h00};
        send_pending(16'd6);
        pending_bytes = '{8'h12, 8'h34, 8'hFF, 8'hFF, 8'h55, 8'h66};
        send_pending(16'hFFFF);
        pending_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h77};
        send_pending(16'd5);
        pending_bytes = '{8'h01, 8'h02, 8'h03};
        send_pending(16'd3);
        send_byte(8'h5A, 1'b0, 16'h1234);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            goal = bytes_sent + ITEM_TARGET / 4;
            while (bytes_sent < goal) begin
                claimed = build_buffer();
                send_pending(16'(claimed));
            end
        end

        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.expected_beats.size() != 0)
            sb.report_mismatch($sformatf("%0d beats never arrived", sb.expected_beats.size()));

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
